/* src/int8_quantized_multiply_accumulate_macros.svh */
// Assertion macros for the requantizing int8 multiply-accumulate block.
// Included by the top level; no other dependencies.
`ifndef INT8_QUANTIZED_MULTIPLY_ACCUMULATE_MACROS_SVH
`define INT8_QUANTIZED_MULTIPLY_ACCUMULATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IQMAC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IQMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/iqmac_pkg.sv */
// Shared widths, register codes and the configuration struct of the
// int8 multiply-accumulate block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iqmac_pkg;

	localparam int ELEM_W   = 8;   // int8 operands, zero-points and result
	localparam int DIFF_W   = 9;   // operand minus zero-point
	localparam int PROD_W   = 18;  // (a-za)*(b-zb)
	localparam int MULT_W   = 32;  // fixed-point multipliers
	localparam int SHIFT_W  = 6;
	localparam int ACC_W    = PROD_W + MULT_W + 1;  // scaled product term / sum
	localparam int ADDEND_W = DIFF_W + MULT_W + 1;  // scaled addend term
	localparam int MAG_W    = 49;                   // |sum| < 2^49
	localparam int VAL_W    = ACC_W + 1;            // signed value after zero-point
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 32;

	localparam logic [IDX_W-1:0] REG_ZERO_POINT_A       = 3'd0;
	localparam logic [IDX_W-1:0] REG_ZERO_POINT_B       = 3'd1;
	localparam logic [IDX_W-1:0] REG_ZERO_POINT_C       = 3'd2;
	localparam logic [IDX_W-1:0] REG_ZERO_POINT_OUT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_PRODUCT_MULTIPLIER = 3'd4;
	localparam logic [IDX_W-1:0] REG_ADDEND_MULTIPLIER  = 3'd5;
	localparam logic [IDX_W-1:0] REG_RESULT_SHIFT       = 3'd6;

	localparam logic [SHIFT_W-1:0] RESULT_SHIFT_RESET = 6'd31;

	localparam logic signed [VAL_W-1:0] SAT_MAX = 52'sd127;
	localparam logic signed [VAL_W-1:0] SAT_MIN = -52'sd128;

	typedef struct packed {
		logic signed [ELEM_W-1:0] zero_point_a;
		logic signed [ELEM_W-1:0] zero_point_b;
		logic signed [ELEM_W-1:0] zero_point_c;
		logic signed [ELEM_W-1:0] zero_point_out;
		logic [MULT_W-1:0]        product_multiplier;
		logic [MULT_W-1:0]        addend_multiplier;
		logic [SHIFT_W-1:0]       result_shift;
	} cfg_t;

endpackage

`default_nettype wire

/* src/iqmac_in_if.sv */
// Operand channel: valid/ready plus the three int8 operands.
// Depends on iqmac_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface iqmac_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [iqmac_pkg::ELEM_W-1:0]   operand_a;
	logic signed [iqmac_pkg::ELEM_W-1:0]   operand_b;
	logic signed [iqmac_pkg::ELEM_W-1:0]   operand_c;

	modport source (output valid, output operand_a, output operand_b, output operand_c,
		input ready);
	modport sink (input valid, input operand_a, input operand_b, input operand_c,
		output ready);
endinterface

`default_nettype wire

/* src/iqmac_out_if.sv */
// Result channel: valid/ready plus the int8 result and saturation flag.
// Depends on iqmac_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface iqmac_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [iqmac_pkg::ELEM_W-1:0]   result;
	logic                                  saturated;

	modport source (output valid, output result, output saturated, input ready);
	modport sink (input valid, input result, input saturated, output ready);
endinterface

`default_nettype wire

/* src/iqmac_cfg_if.sv */
// Configuration write channel: valid/ready, register index and write data.
// Depends on iqmac_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface iqmac_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [iqmac_pkg::IDX_W-1:0]       index;
	logic [iqmac_pkg::DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/iqmac_cfg_regs.sv */
// Configuration register file: decodes write transactions into cfg_t.
// Depends on iqmac_pkg and iqmac_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module iqmac_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	iqmac_cfg_if.sink        cfg,
	output iqmac_pkg::cfg_t  regs
);

	iqmac_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.zero_point_a       <= '0;
			regs_q.zero_point_b       <= '0;
			regs_q.zero_point_c       <= '0;
			regs_q.zero_point_out     <= '0;
			regs_q.product_multiplier <= '0;
			regs_q.addend_multiplier  <= '0;
			regs_q.result_shift       <= iqmac_pkg::RESULT_SHIFT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				iqmac_pkg::REG_ZERO_POINT_A: begin
					regs_q.zero_point_a <= cfg.data[iqmac_pkg::ELEM_W-1:0];
				end
				iqmac_pkg::REG_ZERO_POINT_B: begin
					regs_q.zero_point_b <= cfg.data[iqmac_pkg::ELEM_W-1:0];
				end
				iqmac_pkg::REG_ZERO_POINT_C: begin
					regs_q.zero_point_c <= cfg.data[iqmac_pkg::ELEM_W-1:0];
				end
				iqmac_pkg::REG_ZERO_POINT_OUT: begin
					regs_q.zero_point_out <= cfg.data[iqmac_pkg::ELEM_W-1:0];
				end
				iqmac_pkg::REG_PRODUCT_MULTIPLIER: begin
					regs_q.product_multiplier <= cfg.data[iqmac_pkg::MULT_W-1:0];
				end
				iqmac_pkg::REG_ADDEND_MULTIPLIER: begin
					regs_q.addend_multiplier <= cfg.data[iqmac_pkg::MULT_W-1:0];
				end
				iqmac_pkg::REG_RESULT_SHIFT: begin
					regs_q.result_shift <= cfg.data[iqmac_pkg::SHIFT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/int8_quantized_multiply_accumulate.sv */
// Top level of the requantizing int8 multiply-accumulate pipeline.
// Depends on iqmac_pkg, the three channel interfaces, iqmac_cfg_regs and
// int8_quantized_multiply_accumulate_macros.svh.
//
//  channel    dir   payload                              handshake
//  ---------  ----  -----------------------------------  -----------
//  operands   in    operand_a, operand_b, operand_c      valid/ready
//  results    out   result, saturated                    valid/ready
//  cfg        in    index (3 b), data (32 b)             valid/ready, ready tied high
//
//  Throughput is one transaction per cycle while the output register is
//  not stalled; each input passes stages 1 to 7, the last being the output register.
//  The two wide multiplies (18 x 33 and 9 x 33 bit) in stage 3 set the
//  clock; stage 2 holds a 9 x 9 multiply, the rest a carry chain, negate or shift.
//  All stages advance together; a stalled output register holds the whole
//  pipe, bubbles included, and input ready drops only while it does.
//  Reset clears the valid bits and loads the register defaults
//  (all zero, result shift 31).
`timescale 1ns / 1ps
`default_nettype none
`include "int8_quantized_multiply_accumulate_macros.svh"

module int8_quantized_multiply_accumulate (
	input  wire logic   clk,
	input  wire logic   arst_n,
	iqmac_in_if.sink    operands,
	iqmac_out_if.source results,
	iqmac_cfg_if.sink   cfg
);

	localparam int DIFF_W   = iqmac_pkg::DIFF_W;
	localparam int PROD_W   = iqmac_pkg::PROD_W;
	localparam int ACC_W    = iqmac_pkg::ACC_W;
	localparam int ADDEND_W = iqmac_pkg::ADDEND_W;
	localparam int MAG_W    = iqmac_pkg::MAG_W;
	localparam int VAL_W    = iqmac_pkg::VAL_W;
	localparam int ELEM_W   = iqmac_pkg::ELEM_W;
	localparam int SHIFT_W  = iqmac_pkg::SHIFT_W;

	iqmac_pkg::cfg_t regs;

	iqmac_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// Advance the whole pipe unless the output register holds an untaken result.
	logic adv;
	assign adv            = !v_s7 || results.ready;
	assign operands.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= operands.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: remove zero-points. Each difference lies in -255..255.
	logic signed [DIFF_W-1:0] da_s1, db_s1, dc_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			da_s1 <= {operands.operand_a[ELEM_W-1], operands.operand_a}
				- {regs.zero_point_a[ELEM_W-1], regs.zero_point_a};
			db_s1 <= {operands.operand_b[ELEM_W-1], operands.operand_b}
				- {regs.zero_point_b[ELEM_W-1], regs.zero_point_b};
			dc_s1 <= {operands.operand_c[ELEM_W-1], operands.operand_c}
				- {regs.zero_point_c[ELEM_W-1], regs.zero_point_c};
		end
	end

	// Stage 2: small product of the two factor differences.
	logic signed [PROD_W-1:0] p_s2;
	logic signed [DIFF_W-1:0] dc_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2  <= da_s1 * db_s1;
			dc_s2 <= dc_s1;
		end
	end

	// Stage 3: scale both terms by their unsigned fixed-point multipliers.
	// Zero-extend each multiplier by one bit so the products stay signed.
	logic signed [ACC_W-1:0]    prod_term;
	logic signed [ADDEND_W-1:0] addend_term;
	logic signed [ACC_W-1:0]    prod_s3;
	logic signed [ADDEND_W-1:0] addend_s3;

	assign prod_term   = p_s2 * $signed({1'b0, regs.product_multiplier});
	assign addend_term = dc_s2 * $signed({1'b0, regs.addend_multiplier});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3   <= prod_term;
			addend_s3 <= addend_term;
		end
	end

	// Stage 4: exact sum; magnitude stays below 2^49.
	logic signed [ACC_W-1:0] acc_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s4 <= prod_s3 + {{(ACC_W-ADDEND_W){addend_s3[ADDEND_W-1]}}, addend_s3};
		end
	end

	// Stage 5: split into sign and magnitude; rounding is symmetric about zero.
	logic [ACC_W-1:0]  acc_abs;
	logic              neg_s5;
	logic [MAG_W-1:0]  mag_s5;

	assign acc_abs = acc_s4[ACC_W-1] ? -acc_s4 : acc_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s5 <= acc_s4[ACC_W-1];
			mag_s5 <= acc_abs[MAG_W-1:0];
		end
	end

	// Stage 6: shift right and decide the round-up.
	// Guard is the bit just below the cut, sticky the OR of all bits under it.
	// Round up when guard is set and either sticky or the kept LSB is set
	// (nearest, ties to even). A zero shift passes the magnitude untouched.
	logic [SHIFT_W-1:0] shm1;
	logic [MAG_W-1:0]   quot;
	logic [MAG_W-1:0]   guard_vec;
	logic [MAG_W-1:0]   low_mask;
	logic               shift_nz;
	logic               guard;
	logic               sticky;
	logic               round_up;
	logic               neg_s6;
	logic [MAG_W-1:0]   q_s6;
	logic               ru_s6;

	assign shift_nz  = regs.result_shift != '0;
	assign shm1      = regs.result_shift - SHIFT_W'(1);
	assign quot      = mag_s5 >> regs.result_shift;
	assign guard_vec = mag_s5 >> shm1;
	assign low_mask  = ~({MAG_W{1'b1}} << shm1);
	assign guard     = guard_vec[0];
	assign sticky    = |(mag_s5 & low_mask);
	assign round_up  = shift_nz && guard && (sticky || quot[0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s6 <= neg_s5;
			q_s6   <= quot;
			ru_s6  <= round_up;
		end
	end

	// Stage 7: add the output zero-point, apply sign and round-up, clamp.
	// A negative value adds the complemented magnitude; the carry-in supplies
	// the two's-complement one, less the round-up, so one adder does it all.
	logic [VAL_W-1:0]           q_ext;
	logic [VAL_W-1:0]           q_opnd;
	logic                       carry_in;
	logic signed [VAL_W-1:0]    val;
	logic                       over_hi;
	logic                       over_lo;
	logic signed [ELEM_W-1:0]   result_s7;
	logic                       sat_s7;

	assign q_ext    = {{(VAL_W-MAG_W){1'b0}}, q_s6};
	assign q_opnd   = neg_s6 ? ~q_ext : q_ext;
	assign carry_in = neg_s6 ^ ru_s6;
	assign val      = {{(VAL_W-ELEM_W){regs.zero_point_out[ELEM_W-1]}}, regs.zero_point_out}
		+ q_opnd + {{(VAL_W-1){1'b0}}, carry_in};
	assign over_hi  = val > iqmac_pkg::SAT_MAX;
	assign over_lo  = val < iqmac_pkg::SAT_MIN;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (over_hi) begin
				result_s7 <= iqmac_pkg::SAT_MAX[ELEM_W-1:0];
			end else if (over_lo) begin
				result_s7 <= iqmac_pkg::SAT_MIN[ELEM_W-1:0];
			end else begin
				result_s7 <= val[ELEM_W-1:0];
			end
			sat_s7 <= over_hi || over_lo;
		end
	end

	assign results.valid     = v_s7;
	assign results.result    = result_s7;
	assign results.saturated = sat_s7;

	// An empty output register must never block the input side.
	`IQMAC_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !v_s7, operands.ready, "input stalled with empty output register")
	// A valid item in the last compute stage reaches the output on advance.
	`IQMAC_ASSERT_NEXT(a_valid_travels, clk, arst_n, adv && v_s6, v_s7, "valid bit lost between stage 6 and output")
	// A bubble in the last compute stage must not create a result.
	`IQMAC_ASSERT_NEXT(a_no_phantom, clk, arst_n, adv && !v_s6, !v_s7, "result appeared from an empty stage")
	// A saturated result sits on one of the two int8 rails.
	`IQMAC_ASSERT_IMPL(a_sat_on_rail, clk, arst_n, results.valid && results.saturated, (results.result == 8'sd127) || (results.result == -8'sd128), "saturated flag with in-range result")

endmodule

`default_nettype wire
